// ===== design/rht_pkg.sv =====
package rht_pkg;

  // Table geometry
  localparam int unsigned SLOTS = 16;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [15:0] REFS_MAX = 16'hFFFF;
  localparam logic [31:0] HANDLE_FIRST = 32'd1;

  typedef enum logic [1:0] {
    ACT_CREATE  = 2'd0,
    ACT_LOOKUP  = 2'd1,
    ACT_ADDREF  = 2'd2,
    ACT_RELEASE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // One slot record as held in the slot memory
  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] owner;
    logic [31:0] entry;
    logic [15:0] refs;
  } rec_t;

  // Memory access from the controller
  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;
  } mem_req_t;

  // Result beat handed to the output register
  typedef struct packed {
    status_e     status;
    logic [31:0] issued_handle;
    logic [3:0]  slot_index;
    logic [15:0] found_owner;
    logic [31:0] found_entry;
    logic [15:0] ref_count;
  } result_t;

endpackage

// ===== design/rht_mem.sv =====
module rht_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rht_pkg::mem_req_t req_i,
  output rht_pkg::rec_t     rd_data_o
);

  rht_pkg::rec_t               mem [rht_pkg::SLOTS];
  logic [rht_pkg::SLOTS-1:0]   written_q;
  rht_pkg::rec_t               rd_q;
  logic                        rd_written_q;

  // Write and read the record array; the read data is registered
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_q <= mem[req_i.rd_addr];
  end

  // Track entries written since reset; others read as a free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.wr_addr] <= 1'b1;
      end
      rd_written_q <= written_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_written_q ? rd_q : '0;

endmodule

// ===== design/rht_ctrl.sv =====
module rht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [31:0]       handle_i,
  input  logic [15:0]       owner_i,
  input  logic [31:0]       entry_ref_i,
  output rht_pkg::mem_req_t mem_req_o,
  input  rht_pkg::rec_t     rd_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output rht_pkg::result_t  res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_e;

  state_e                    state_q, state_d;
  logic [rht_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [31:0]               issue_q, issue_d;
  rht_pkg::result_t          res_q, res_d;

  rht_pkg::action_e          act_q;
  logic [31:0]               hdl_q;
  logic [15:0]               own_q;
  logic [31:0]               ent_q;

  logic                      accept;
  logic                      hit;
  logic                      last;
  logic [31:0]               issue_inc;
  rht_pkg::rec_t             wr_rec;
  logic                      wr_en;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign last       = (idx_q == rht_pkg::IDX_W'(rht_pkg::SLOTS - 1));
  assign issue_inc  = issue_q + 32'd1;

  // Match the slot read back against the request
  always_comb begin
    if (act_q == rht_pkg::ACT_CREATE) begin
      hit = (rd_data_i.handle == 32'd0);
    end else begin
      hit = (hdl_q != 32'd0) && (rd_data_i.handle == hdl_q);
    end
  end

  // Next state, write-back record and result
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    issue_d = issue_q;
    res_d   = res_q;
    wr_en   = 1'b0;
    wr_rec  = rd_data_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          idx_d   = '0;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d                = S_RESULT;
          res_d.status           = rht_pkg::ST_OK;
          res_d.issued_handle    = 32'd0;
          res_d.slot_index       = 4'(idx_q);
          res_d.found_owner      = rd_data_i.owner;
          res_d.found_entry      = rd_data_i.entry;
          res_d.ref_count        = rd_data_i.refs;
          case (act_q)
            rht_pkg::ACT_CREATE: begin
              wr_en               = 1'b1;
              wr_rec.handle       = issue_q;
              wr_rec.owner        = own_q;
              wr_rec.entry        = ent_q;
              wr_rec.refs         = 16'd1;
              issue_d             = (issue_inc == 32'd0) ? rht_pkg::HANDLE_FIRST : issue_inc;
              res_d.issued_handle = issue_q;
              res_d.found_owner   = own_q;
              res_d.found_entry   = ent_q;
              res_d.ref_count     = 16'd1;
            end
            rht_pkg::ACT_ADDREF: begin
              wr_en = 1'b1;
              if (rd_data_i.refs != rht_pkg::REFS_MAX) begin
                wr_rec.refs = rd_data_i.refs + 16'd1;
              end
              res_d.ref_count = wr_rec.refs;
            end
            rht_pkg::ACT_RELEASE: begin
              wr_en = 1'b1;
              if (rd_data_i.refs <= 16'd1) begin
                wr_rec = '0;
              end else begin
                wr_rec.refs = rd_data_i.refs - 16'd1;
              end
              res_d.ref_count = wr_rec.refs;
            end
            default: begin
              wr_en = 1'b0;
            end
          endcase
        end else if (last) begin
          // Scan ran out: report failure with all other fields zero
          state_d = S_RESULT;
          res_d   = '0;
          res_d.status = (act_q == rht_pkg::ACT_CREATE) ? rht_pkg::ST_FULL
                                                        : rht_pkg::ST_NOT_FOUND;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Read slot zero while idle, otherwise the slot after the one checked
  always_comb begin
    mem_req_o.rd_addr = (state_q == S_IDLE) ? '0 : idx_q + 1'b1;
    mem_req_o.wr_en   = wr_en;
    mem_req_o.wr_addr = idx_q;
    mem_req_o.wr_data = wr_rec;
  end

  // Hold state, issue counter and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      issue_q <= rht_pkg::HANDLE_FIRST;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      issue_q <= issue_d;
      res_q   <= res_d;
    end
  end

  // Capture the request beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= rht_pkg::action_e'(action_i);
      hdl_q <= handle_i;
      own_q <= owner_i;
      ent_q <= entry_ref_i;
    end
  end

  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

endmodule

// ===== design/refcounted_handle_table_top.sv =====
// A request is accepted only while idle; the controller then checks the slots in order
// from slot zero until a match or the last slot, then hands the result to the output register.
// A new request waits until that result is taken, since the serial slot scan runs
// through the single read port of the slot memory, one slot per cycle.
// Reset (rst_ni low, asynchronous): all slots free, next handle is one, no result pending.
module refcounted_handle_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] handle_i,
  input  logic [15:0] owner_i,
  input  logic [31:0] entry_ref_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] issued_handle_o,
  output logic [3:0]  slot_index_o,
  output logic [15:0] found_owner_o,
  output logic [31:0] found_entry_o,
  output logic [15:0] ref_count_o
);

  rht_pkg::mem_req_t mem_req;
  rht_pkg::rec_t     rd_data;
  logic              res_valid;
  logic              res_ready;
  rht_pkg::result_t  res;
  logic              out_valid_q;
  rht_pkg::result_t  out_q;

  rht_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  rht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .handle_i    (handle_i),
    .owner_i     (owner_i),
    .entry_ref_i (entry_ref_i),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Load the output register when it is empty or its beat is taken
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign issued_handle_o = out_q.issued_handle;
  assign slot_index_o    = out_q.slot_index;
  assign found_owner_o   = out_q.found_owner;
  assign found_entry_o   = out_q.found_entry;
  assign ref_count_o     = out_q.ref_count;

endmodule

// ===== tb/sv/refcounted_handle_table_top_test.sv =====
module refcounted_handle_table_top_test;
  import rht_pkg::*;

  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = SLOTS + 4;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i        = '0;
  logic [31:0] handle_i        = '0;
  logic [15:0] owner_i         = '0;
  logic [31:0] entry_ref_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] issued_handle_o;
  logic [3:0]  slot_index_o;
  logic [15:0] found_owner_o;
  logic [31:0] found_entry_o;
  logic [15:0] ref_count_o;

  refcounted_handle_table_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the slot table
  logic [31:0] tbl_handle [SLOTS];
  logic [15:0] tbl_owner  [SLOTS];
  logic [31:0] tbl_entry  [SLOTS];
  logic [15:0] tbl_refs   [SLOTS];
  logic [31:0] exp_issue;
  logic [31:0] last_freed = '0;

  result_t expected_results [$];
  result_t head_result;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int cycle_cnt     = 0;
  int err_cnt       = 0;
  int n_results     = 0;
  int n_created     = 0;
  int n_full        = 0;
  int n_not_found   = 0;
  int n_freed       = 0;

  function automatic int first_free_slot();
    int i;
    for (i = 0; i < SLOTS; i++)
      if (tbl_handle[i] == '0) return i;
    return -1;
  endfunction

  // Apply one request to the shadow table and return the beat it must produce
  function automatic result_t apply_table_op(action_e act, logic [31:0] h,
                                             logic [15:0] own, logic [31:0] ent);
    result_t r;
    int s;
    int i;
    r = '0;
    r.status = ST_OK;
    if (act == ACT_CREATE) begin
      s = first_free_slot();
      if (s < 0) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        r.issued_handle = exp_issue;
        tbl_handle[s] = exp_issue;
        tbl_owner[s]  = own;
        tbl_entry[s]  = ent;
        tbl_refs[s]   = 16'd1;
        // advance the issue counter, skipping zero on wrap
        exp_issue = exp_issue + 32'd1;
        if (exp_issue == '0) exp_issue = HANDLE_FIRST;
        r.slot_index  = 4'(s);
        r.found_owner = own;
        r.found_entry = ent;
        r.ref_count   = 16'd1;
        n_created++;
      end
    end else begin
      // scan downward so the lowest matching slot wins; handle zero never matches
      s = -1;
      if (h != '0)
        for (i = SLOTS - 1; i >= 0; i--)
          if (tbl_handle[i] == h) s = i;
      if (s < 0) begin
        r.status = ST_NOT_FOUND;
        n_not_found++;
      end else begin
        r.slot_index  = 4'(s);
        r.found_owner = tbl_owner[s];
        r.found_entry = tbl_entry[s];
        case (act)
          ACT_ADDREF: begin
            if (tbl_refs[s] != REFS_MAX) tbl_refs[s] = tbl_refs[s] + 16'd1;
          end
          ACT_RELEASE: begin
            if (tbl_refs[s] <= 16'd1) begin
              tbl_handle[s] = '0;
              tbl_owner[s]  = '0;
              tbl_entry[s]  = '0;
              tbl_refs[s]   = '0;
              last_freed    = h;
              n_freed++;
            end else begin
              tbl_refs[s] = tbl_refs[s] - 16'd1;
            end
          end
          default: ;
        endcase
        r.ref_count = tbl_refs[s];
      end
    end
    return r;
  endfunction

  // Mostly live handles, the rest zero, stale, not yet issued or random
  function automatic logic [31:0] choose_handle();
    int live [$];
    int i;
    int r;
    for (i = 0; i < SLOTS; i++)
      if (tbl_handle[i] != '0) live.push_back(i);
    r = $urandom_range(0, 99);
    if (r < 82 && live.size() > 0) return tbl_handle[live[$urandom_range(0, live.size() - 1)]];
    if (r < 88) return '0;
    if (r < 93) return last_freed;
    if (r < 96) return exp_issue;
    return $urandom;
  endfunction

  // Offer one beat after a random gap and record its expected result on accept
  task automatic send_request(action_e act, logic [31:0] h, logic [15:0] own,
                              logic [31:0] ent);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    handle_i    <= h;
    owner_i     <= own;
    entry_ref_i <= ent;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(apply_table_op(act, h, own, ent));
  endtask

  task automatic sender_rest();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  // Receiver: random stalls, or a forced hold-off while hold_left runs down
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_results.size() == 0) begin
        err_cnt++;
        $display("%0t: result beat with none expected, status %0h handle %0h",
                 $time, status_o, issued_handle_o);
      end else begin
        head_result = expected_results.pop_front();
        check_field("status", 32'(head_result.status), 32'(status_o));
        check_field("issued_handle", head_result.issued_handle, issued_handle_o);
        check_field("slot_index", 32'(head_result.slot_index), 32'(slot_index_o));
        check_field("found_owner", 32'(head_result.found_owner), 32'(found_owner_o));
        check_field("found_entry", head_result.found_entry, found_entry_o);
        check_field("ref_count", 32'(head_result.ref_count), 32'(ref_count_o));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Handle zero and unknown handles on an empty table
  task automatic test_zero_handle();
    send_idle_pct = 22;
    recv_idle_pct = 54;
    send_request(ACT_LOOKUP, '0, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(ACT_ADDREF, '0, '0, '0);
    send_request(ACT_RELEASE, '0, '0, '0);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    sender_rest();
    wait_drained();
  endtask

  // Raise one count in slot zero, then release it step by step until the slot is free
  task automatic test_ref_counting();
    logic [31:0] h;
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    h = exp_issue;
    send_request(ACT_CREATE, '0, 16'h5A5A, 32'h1234_5678);
    for (k = 0; k < 20; k++) send_request(ACT_ADDREF, h, '0, '0);
    for (k = 0; k < 21; k++) send_request(ACT_RELEASE, h, '0, '0);
    send_request(ACT_ADDREF, h, '0, '0);
    send_request(ACT_LOOKUP, h, '0, '0);
    sender_rest();
    wait_drained();
  endtask

  // Field extremes on create, then each operation and a release down to free
  task automatic test_create_fields();
    logic [31:0] ha;
    logic [31:0] hb;
    send_idle_pct = 22;
    recv_idle_pct = 54;
    ha = exp_issue;
    hb = exp_issue + 32'd1;
    send_request(ACT_CREATE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(ACT_CREATE, '0, '0, '0);
    send_request(ACT_LOOKUP, ha, '0, '0);
    send_request(ACT_LOOKUP, hb, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(ACT_ADDREF, hb, '0, '0);
    send_request(ACT_RELEASE, hb, '0, '0);
    send_request(ACT_RELEASE, hb, '0, '0);
    send_request(ACT_LOOKUP, hb, '0, '0);
    send_request(ACT_RELEASE, ha, '0, '0);
    sender_rest();
    wait_drained();
  endtask

  // Fill every slot, hit table full, then reuse a freed slot
  task automatic test_table_full();
    logic [31:0] h;
    send_idle_pct = 22;
    recv_idle_pct = 54;
    while (first_free_slot() >= 0) send_request(ACT_CREATE, $urandom, 16'($urandom), $urandom);
    send_request(ACT_CREATE, '0, 16'h1111, 32'h2222_2222);
    send_request(ACT_CREATE, '0, 16'h3333, 32'h4444_4444);
    h = tbl_handle[5];
    send_request(ACT_RELEASE, h, '0, '0);
    send_request(ACT_CREATE, h, 16'hBEEF, 32'hCAFE_F00D);
    send_request(ACT_LOOKUP, h, '0, '0);
    send_request(ACT_LOOKUP, tbl_handle[SLOTS - 1], '0, '0);
    sender_rest();
    wait_drained();
  endtask

  // Hold the receiver off while requests keep coming so the input backs up
  task automatic test_backpressure();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    for (k = 0; k < 12; k++)
      send_request(action_e'($urandom_range(0, 3)), choose_handle(), 16'($urandom), $urandom);
    sender_rest();
    wait_drained();
  endtask

  // Weighted random traffic over live handles with some noise
  task automatic test_random_mix(int n_items, int snd_pct, int rcv_pct);
    int k;
    int pick;
    action_e act;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) act = ACT_CREATE;
      else if (pick < 50) act = ACT_LOOKUP;
      else if (pick < 65) act = ACT_ADDREF;
      else act = ACT_RELEASE;
      send_request(act, choose_handle(), 16'($urandom), $urandom);
    end
    sender_rest();
    wait_drained();
  endtask

  initial begin
    int i;
    for (i = 0; i < SLOTS; i++) begin
      tbl_handle[i] = '0;
      tbl_owner[i]  = '0;
      tbl_entry[i]  = '0;
      tbl_refs[i]   = '0;
    end
    exp_issue = HANDLE_FIRST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_handle();
    test_ref_counting();
    test_create_fields();
    test_table_full();
    test_backpressure();
    test_random_mix(340, 22, 54);
    test_random_mix(340, 54, 22);
    test_random_mix(340, 0, 0);

    $display("Checked %0d result beats: %0d creates, %0d table full, %0d not found, %0d freed",
             n_results, n_created, n_full, n_not_found, n_freed);
    $display("Covered count up and down, full table, stale handles and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
